### rtl/palreg_pkg.sv
`default_nettype none

package palreg_pkg;

   // Default number of entries in each palette
   localparam int ENTRIES_DEFAULT = 256;

   // Eight palettes: four layers in each of two banks
   localparam int PALETTES = 8;

   // Memory word: priority in the top two bits, RGB333 below
   localparam int COLOUR_W = 9;
   localparam int PRIO_W   = 2;
   localparam int WORD_W   = COLOUR_W + PRIO_W;

   // Layers inside a bank
   localparam logic [1:0] LAYER_ULA     = 2'd0;
   localparam logic [1:0] LAYER_LAYER2  = 2'd1;
   localparam logic [1:0] LAYER_SPRITES = 2'd2;
   localparam logic [1:0] LAYER_TILEMAP = 2'd3;

   // Access codes
   typedef enum logic [2:0] {
      OP_CONTROL = 3'd0,
      OP_INDEX   = 3'd1,
      OP_WRITE8  = 3'd2,
      OP_WRITE9  = 3'd3,
      OP_READ8   = 3'd4,
      OP_READ9   = 3'd5,
      OP_POKE    = 3'd6
   } op_type;

   // Which byte a read beat returns
   typedef enum logic [1:0] {
      RD_NONE   = 2'd0,
      RD_COLOUR = 2'd1,
      RD_PRIO   = 2'd2
   } rd_type;

   // Sequencer states
   typedef enum logic {
      ST_INIT = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic        poke_bank;
      logic [5:0]  poke_slot;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  index_now;
      logic [2:0]  target_now;
      logic        auto_inc_off;
      logic        ula_alt_bank;
      logic        layer2_alt_bank;
      logic        sprite_alt_bank;
      logic        extended_mode;
      logic        latch_pending;
   } rsp_type;

   // Sixteen standard colours of the ULA palettes
   localparam logic [COLOUR_W-1:0] BOOT_COLOURS [16] = '{
      9'h000, 9'h006, 9'h180, 9'h186, 9'h030, 9'h036, 9'h1B0, 9'h1B6,
      9'h000, 9'h007, 9'h1C0, 9'h1C7, 9'h038, 9'h03F, 9'h1F8, 9'h1FF
   };

   // Expand RRRGGGBB to RRRGGGBBB, new blue LSB is B1 or B0
   function automatic logic [COLOUR_W-1:0] expand8(input logic [7:0] v);
      return {v[7:5], v[4:2], v[1:0], v[1] | v[0]};
   endfunction

   // Colour that an entry holds after reset
   function automatic logic [COLOUR_W-1:0] boot_colour(input logic [1:0] layer,
                                                       input logic [7:0] idx);
      logic [COLOUR_W-1:0] c;
      c = '0;
      unique case (layer)
         LAYER_ULA:     c = (idx < 8'd32) ? BOOT_COLOURS[idx[3:0]] : expand8(idx);
         LAYER_LAYER2:  c = expand8(idx);
         LAYER_SPRITES: c = expand8(idx);
         LAYER_TILEMAP: c = '0;
         default:       c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/palreg_ram.sv
`default_nettype none

module palreg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [$clog2(DEPTH)-1:0]  addr,
   input  wire logic [WIDTH-1:0]          wdata,
   output logic      [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/palette_register_port.sv
// Channel   Ports                        Handshake
// -------   --------------------------   -----------------------------------
// request   start, busy, req_payload     beat taken when start && !busy
// response  rsp_strobe, rsp_payload      one cycle per beat, no back-pressure
//
// One beat per cycle while busy is low; each response appears the cycle after its request,
// set by the registered read of the single-port palette RAM.
// After reset busy stays high while the boot colours are written into every
// entry of all eight palettes in the RAM, one entry a cycle.
// The receiver cannot stall; responses are never held.
// Poke beats are acknowledged but have no readback path on this port.
`default_nettype none

module palette_register_port #(
   parameter int ENTRIES = palreg_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire palreg_pkg::req_type req_payload,
   output logic                     rsp_strobe,
   output palreg_pkg::rsp_type      rsp_payload
);

   import palreg_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int DEPTH = PALETTES * ENTRIES;
   localparam int AW    = $clog2(DEPTH);
   localparam int RECIP = 65536 / ENTRIES;

   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ENTRIES - 1);
   localparam logic [AW-1:0]    ENTRIES_A = AW'(ENTRIES);
   localparam logic [8:0]       ENTRIES_9 = 9'(ENTRIES);

   // Control and status
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  pointer_ff, pointer_in;
   logic [7:0]        control_ff, control_in;
   logic              latch_full_ff, latch_full_in;
   logic [7:0]        latch_byte_ff, latch_byte_in;
   logic [2:0]        init_pal_ff, init_pal_in;
   logic [IDX_W-1:0]  init_idx_ff, init_idx_in;
   logic              valid_ff;
   rd_type            rd_sel_ff, rd_sel_in;

   logic              accept;
   logic              init_we;
   logic              init_last;
   logic [IDX_W-1:0]  pointer_step;
   logic [IDX_W-1:0]  index_mod;

   // RAM port
   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;

   // Index reduction modulo ENTRIES
   logic [24:0]       idx_prod;
   logic [7:0]        idx_quot;
   logic [8:0]        idx_rem;

   assign accept    = start && !busy;
   assign init_last = (init_pal_ff == 3'd7) && (init_idx_ff == IDX_LAST);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: if (init_last) state_in = ST_RUN;
         ST_RUN:  state_in = ST_RUN;
         default: state_in = ST_INIT;
      endcase
   end

   // State outputs
   always_comb begin
      busy    = 1'b1;
      init_we = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            busy    = 1'b1;
            init_we = 1'b1;
         end
         ST_RUN: begin
            busy    = 1'b0;
            init_we = 1'b0;
         end
         default: begin
            busy    = 1'b1;
            init_we = 1'b0;
         end
      endcase
   end

   // Advance the boot sweep through every palette
   always_comb begin
      init_pal_in = init_pal_ff;
      init_idx_in = init_idx_ff;
      if (init_we) begin
         if (init_idx_ff == IDX_LAST) begin
            init_idx_in = '0;
            init_pal_in = init_pal_ff + 3'd1;
         end else begin
            init_idx_in = init_idx_ff + IDX_W'(1);
         end
      end
   end

   // Reduce an index byte modulo ENTRIES: reciprocal, then one correction
   always_comb begin
      idx_prod = 25'(req_payload.data) * 25'(RECIP);
      idx_quot = idx_prod[23:16];
      idx_rem  = {1'b0, req_payload.data} - 9'(9'(idx_quot) * ENTRIES_9);
      if (idx_rem >= ENTRIES_9) begin
         idx_rem = idx_rem - ENTRIES_9;
      end
      index_mod = idx_rem[IDX_W-1:0];
   end

   // Wrap the pointer unless auto-increment is off
   always_comb begin
      if (control_ff[7]) begin
         pointer_step = pointer_ff;
      end else if (pointer_ff == IDX_LAST) begin
         pointer_step = '0;
      end else begin
         pointer_step = pointer_ff + IDX_W'(1);
      end
   end

   // Decode the request beat, drive the RAM
   always_comb begin
      pointer_in    = pointer_ff;
      control_in    = control_ff;
      latch_full_in = latch_full_ff;
      latch_byte_in = latch_byte_ff;
      rd_sel_in     = RD_NONE;
      ram_we        = 1'b0;
      ram_addr      = AW'(control_ff[6:4]) * ENTRIES_A + AW'(pointer_ff);
      ram_wdata     = {2'b00, expand8(req_payload.data)};

      if (init_we) begin
         ram_we    = 1'b1;
         ram_addr  = AW'(init_pal_ff) * ENTRIES_A + AW'(init_idx_ff);
         ram_wdata = {2'b00, boot_colour(init_pal_ff[1:0], 8'(init_idx_ff))};
      end else if (accept) begin
         unique case (req_payload.op)
            OP_CONTROL: begin
               control_in    = req_payload.data;
               latch_full_in = 1'b0;
            end
            OP_INDEX: begin
               pointer_in    = index_mod;
               latch_full_in = 1'b0;
            end
            OP_WRITE8: begin
               latch_full_in = 1'b0;
               ram_we        = 1'b1;
               pointer_in    = pointer_step;
            end
            OP_WRITE9: begin
               if (!latch_full_ff) begin
                  latch_byte_in = req_payload.data;
                  latch_full_in = 1'b1;
               end else begin
                  latch_full_in = 1'b0;
                  ram_we        = 1'b1;
                  ram_wdata     = {req_payload.data[7:6], latch_byte_ff,
                                   req_payload.data[0]};
                  pointer_in    = pointer_step;
               end
            end
            OP_READ8: rd_sel_in = RD_COLOUR;
            OP_READ9: rd_sel_in = RD_PRIO;
            OP_POKE:  rd_sel_in = RD_NONE;
            default:  rd_sel_in = RD_NONE;
         endcase
      end
   end

   palreg_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         pointer_ff    <= '0;
         control_ff    <= '0;
         latch_full_ff <= 1'b0;
         init_pal_ff   <= '0;
         init_idx_ff   <= '0;
         valid_ff      <= 1'b0;
         rd_sel_ff     <= RD_NONE;
      end else begin
         state_ff      <= state_in;
         pointer_ff    <= pointer_in;
         control_ff    <= control_in;
         latch_full_ff <= latch_full_in;
         init_pal_ff   <= init_pal_in;
         init_idx_ff   <= init_idx_in;
         valid_ff      <= accept;
         rd_sel_ff     <= rd_sel_in;
      end
   end

   // Hold the first byte of a 9-bit write
   always_ff @(posedge clock) begin
      latch_byte_ff <= latch_byte_in;
   end

   // Response beat: state after the access plus the RAM read byte
   always_comb begin
      rsp_strobe = valid_ff;
      unique case (rd_sel_ff)
         RD_COLOUR: rsp_payload.read_data = ram_rdata[8:1];
         RD_PRIO:   rsp_payload.read_data = {ram_rdata[10:9], 5'b00000, ram_rdata[0]};
         RD_NONE:   rsp_payload.read_data = 8'h00;
         default:   rsp_payload.read_data = 8'h00;
      endcase
      rsp_payload.index_now       = 8'(pointer_ff);
      rsp_payload.target_now      = control_ff[6:4];
      rsp_payload.auto_inc_off    = control_ff[7];
      rsp_payload.ula_alt_bank    = control_ff[1];
      rsp_payload.layer2_alt_bank = control_ff[2];
      rsp_payload.sprite_alt_bank = control_ff[3];
      rsp_payload.extended_mode   = control_ff[0];
      rsp_payload.latch_pending   = latch_full_ff;
   end

endmodule

`default_nettype wire

### test/palette_register_port_tb.sv
module palette_register_port_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import palreg_pkg::*;

   // One row of the directed table; the expected fields are used only when typed is set
   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic        bank;
      logic [5:0]  slot;
      logic        typed;
      logic [7:0]  rd;
      logic [7:0]  idx;
      logic [7:0]  ctrl;
      logic        latch;
   } table_row_type;

   // One request beat of the run
   typedef struct {
      req_type  req;
      bit       typed;
      rsp_type  want;
      bit       drain;
   } plan_beat_type;

   localparam int NROWS = 27;
   localparam int RANDOM_BEATS = 1500;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   req_type  req_payload;
   logic     rsp_strobe;
   rsp_type  rsp_payload;

   // Predicted palette contents and port registers
   logic [8:0]  shade_mem [2048];
   logic [1:0]  prio_mem [2048];
   logic [7:0]  ptr_q;
   logic [7:0]  ctrl_q;
   logic [7:0]  latch_byte_q;
   logic        latch_q;

   plan_beat_type  beat_plan [$];
   rsp_type        pending_rsp [$];
   table_row_type  directed_rows [NROWS];

   int fault_count = 0;
   int beats_checked = 0;
   int drain_count = 0;
   int ops_sent [8];

   palette_register_port i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("palette_register_port: mismatch");
      $finish;
   end

   // Expand RRRGGGBB to RRRGGGBBB; the extra blue bit is the OR of the two given
   function automatic logic [8:0] rgb333_of_byte(input logic [7:0] v);
      return {v[7:2], v[1:0], v[1] | v[0]};
   endfunction

   // Write one entry and advance the pointer unless auto-increment is off
   function automatic void commit_entry(input logic [10:0] addr, input logic [8:0] rgb,
                                        input logic [1:0] pr);
      shade_mem[addr] = rgb;
      prio_mem[addr] = pr;
      if (!ctrl_q[7]) ptr_q = ptr_q + 8'd1;
   endfunction

   // Apply one access to the predicted state and return the response it should give
   function automatic rsp_type predict_port_access(input req_type r);
      logic [10:0] addr;
      logic [7:0]  rd;
      rsp_type     p;
      addr = {ctrl_q[6:4], ptr_q};
      rd = 8'h00;
      case (r.op)
         OP_CONTROL: begin
            ctrl_q = r.data;
            latch_q = 1'b0;
         end
         OP_INDEX: begin
            ptr_q = r.data;
            latch_q = 1'b0;
         end
         OP_WRITE8: begin
            latch_q = 1'b0;
            commit_entry(addr, rgb333_of_byte(r.data), 2'd0);
         end
         OP_WRITE9: begin
            if (!latch_q) begin
               latch_byte_q = r.data;
               latch_q = 1'b1;
            end else begin
               latch_q = 1'b0;
               commit_entry(addr, {latch_byte_q, r.data[0]}, r.data[7:6]);
            end
         end
         OP_READ8: rd = shade_mem[addr][8:1];
         OP_READ9: rd = {prio_mem[addr], 5'b00000, shade_mem[addr][0]};
         default: rd = 8'h00;
      endcase
      p.read_data       = rd;
      p.index_now       = ptr_q;
      p.target_now      = ctrl_q[6:4];
      p.auto_inc_off    = ctrl_q[7];
      p.sprite_alt_bank = ctrl_q[3];
      p.layer2_alt_bank = ctrl_q[2];
      p.ula_alt_bank    = ctrl_q[1];
      p.extended_mode   = ctrl_q[0];
      p.latch_pending   = latch_q;
      return p;
   endfunction

   // Append one untyped beat with random poke fields
   task automatic queue_beat(input op_type op, input logic [7:0] data);
      plan_beat_type b;
      b.req.op        = op;
      b.req.data      = data;
      b.req.poke_bank = 1'($urandom_range(0, 1));
      b.req.poke_slot = 6'($urandom_range(0, 63));
      b.typed = 1'b0;
      b.want  = '0;
      b.drain = 1'b0;
      beat_plan.push_back(b);
   endtask

   // Build the plan, reset the block, then send every beat
   initial begin : stimulus
      plan_beat_type  b;
      rsp_type        predicted;
      logic [7:0]     ctl;
      logic [7:0]     base;
      int             n_directed;
      int             kind;
      int             run;
      int             gap;
      int             burst_left;
      int             roll;

      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      burst_left = 0;
      foreach (ops_sent[k]) ops_sent[k] = 0;

      // Boot colours of the predicted palettes
      for (int p = 0; p < 8; p++) begin
         for (int e = 0; e < 256; e++) begin
            case (2'(p))
               LAYER_ULA:     shade_mem[p*256 + e] = (e < 32) ? BOOT_COLOURS[e % 16]
                                                              : rgb333_of_byte(8'(e));
               LAYER_LAYER2,
               LAYER_SPRITES: shade_mem[p*256 + e] = rgb333_of_byte(8'(e));
               default:       shade_mem[p*256 + e] = 9'h000;
            endcase
            prio_mem[p*256 + e] = 2'd0;
         end
      end
      ptr_q = 8'h00;
      ctrl_q = 8'h00;
      latch_q = 1'b0;
      latch_byte_q = 8'h00;

      // op, data, poke bank, poke slot, typed, read_data, index, control, latch
      directed_rows = '{
         '{OP_READ8,   8'h00, 1'b0, 6'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_INDEX,   8'h0F, 1'b0, 6'h00, 1'b1, 8'h00, 8'h0F, 8'h00, 1'b0},
         '{OP_READ8,   8'h00, 1'b0, 6'h00, 1'b1, 8'hFF, 8'h0F, 8'h00, 1'b0},
         '{OP_READ9,   8'h00, 1'b0, 6'h00, 1'b1, 8'h01, 8'h0F, 8'h00, 1'b0},
         '{OP_INDEX,   8'hFF, 1'b0, 6'h00, 1'b1, 8'h00, 8'hFF, 8'h00, 1'b0},
         '{OP_READ8,   8'h00, 1'b0, 6'h00, 1'b1, 8'hFF, 8'hFF, 8'h00, 1'b0},
         '{OP_CONTROL, 8'hFF, 1'b0, 6'h00, 1'b1, 8'h00, 8'hFF, 8'hFF, 1'b0},
         '{OP_READ8,   8'h00, 1'b0, 6'h00, 1'b1, 8'h00, 8'hFF, 8'hFF, 1'b0},
         '{OP_WRITE8,  8'hFF, 1'b0, 6'h00, 1'b1, 8'h00, 8'hFF, 8'hFF, 1'b0},
         '{OP_READ9,   8'h00, 1'b0, 6'h00, 1'b1, 8'h01, 8'hFF, 8'hFF, 1'b0},
         '{OP_CONTROL, 8'h30, 1'b0, 6'h00, 1'b1, 8'h00, 8'hFF, 8'h30, 1'b0},
         '{OP_WRITE9,  8'h00, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_WRITE9,  8'hC1, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_INDEX,   8'hFF, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_READ9,   8'h00, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_READ8,   8'h00, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_WRITE9,  8'hAA, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_CONTROL, 8'h0E, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_WRITE9,  8'h55, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_INDEX,   8'h10, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_WRITE9,  8'h12, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_WRITE8,  8'h01, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_WRITE9,  8'h34, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_READ8,   8'h00, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_POKE,    8'hFF, 1'b1, 6'h3F, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{OP_WRITE9,  8'h80, 1'b0, 6'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
         '{op_type'(3'd7), 8'hFF, 1'b1, 6'h3F, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0}
      };

      // Walk the table into the plan
      foreach (directed_rows[r]) begin
         b.req.op        = directed_rows[r].op;
         b.req.data      = directed_rows[r].data;
         b.req.poke_bank = directed_rows[r].bank;
         b.req.poke_slot = directed_rows[r].slot;
         b.typed = directed_rows[r].typed;
         b.want.read_data       = directed_rows[r].rd;
         b.want.index_now       = directed_rows[r].idx;
         b.want.target_now      = directed_rows[r].ctrl[6:4];
         b.want.auto_inc_off    = directed_rows[r].ctrl[7];
         b.want.sprite_alt_bank = directed_rows[r].ctrl[3];
         b.want.layer2_alt_bank = directed_rows[r].ctrl[2];
         b.want.ula_alt_bank    = directed_rows[r].ctrl[1];
         b.want.extended_mode   = directed_rows[r].ctrl[0];
         b.want.latch_pending   = directed_rows[r].latch;
         b.drain = 1'b0;
         beat_plan.push_back(b);
      end
      n_directed = beat_plan.size();

      // Random part: mostly program-then-read-back sequences, the rest loose accesses
      while (beat_plan.size() - n_directed < RANDOM_BEATS) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            ctl = 8'($urandom);
            if ($urandom_range(0, 3) != 0) ctl[7] = 1'b0;
            base = ($urandom_range(0, 3) == 0) ? 8'(8'hF8 + $urandom_range(0, 7))
                                               : 8'($urandom);
            run = $urandom_range(1, 8);
            queue_beat(OP_CONTROL, ctl);
            queue_beat(OP_INDEX, base);
            for (int k = 0; k < run; k++) begin
               if ($urandom_range(0, 1) == 1) begin
                  queue_beat(OP_WRITE8, 8'($urandom));
               end else begin
                  queue_beat(OP_WRITE9, 8'($urandom));
                  queue_beat(OP_WRITE9, 8'($urandom));
               end
               if ($urandom_range(0, 7) == 0) queue_beat(OP_POKE, 8'($urandom));
            end
            queue_beat(OP_INDEX, base);
            for (int k = 0; k < run; k++) begin
               roll = $urandom_range(0, 2);
               if (roll != 1) queue_beat(OP_READ8, 8'($urandom));
               if (roll != 0) queue_beat(OP_READ9, 8'($urandom));
               if (ctl[7] == 1'b0 && roll == 0) queue_beat(OP_WRITE8, 8'($urandom));
            end
         end else begin
            run = $urandom_range(1, 6);
            for (int k = 0; k < run; k++)
               queue_beat(op_type'($urandom_range(0, 6)), 8'($urandom));
         end
      end

      // Pause for a full drain now and then
      for (int j = n_directed; j < beat_plan.size(); j += 400) beat_plan[j].drain = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Send the beats with random idle gaps
      for (int i = 0; i < beat_plan.size(); i++) begin
         if (burst_left > 0) begin
            burst_left--;
            gap = 0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               burst_left = $urandom_range(20, 60);
               gap = 0;
            end else if (roll < 50) begin
               gap = 0;
            end else if (roll < 92) begin
               gap = $urandom_range(1, 3);
            end else begin
               gap = $urandom_range(10, 40);
            end
         end
         if (beat_plan[i].drain && gap == 0) gap = 1;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
            if (beat_plan[i].drain) begin
               drain_count++;
               while (pending_rsp.size() != 0) @(posedge clock);
            end
         end
         start <= 1'b1;
         req_payload <= beat_plan[i].req;
         @(posedge clock);
         while (busy !== 1'b0) @(posedge clock);
         predicted = predict_port_access(beat_plan[i].req);
         pending_rsp.push_back(beat_plan[i].typed ? beat_plan[i].want : predicted);
         ops_sent[int'(beat_plan[i].req.op)]++;
      end
      start <= 1'b0;

      // Drain, then give stray responses a chance to show up
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d request beats (%0d directed), %0d responses, %0d drained pauses",
               beat_plan.size(), n_directed, beats_checked, drain_count);
      $display("mix: control %0d index %0d write8 %0d write9 %0d read8 %0d read9 %0d poke %0d",
               ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3], ops_sent[4],
               ops_sent[5], ops_sent[6]);
      if (fault_count == 0) begin
         $display("palette_register_port: match");
      end else begin
         $display("%0d faulty responses", fault_count);
         $display("palette_register_port: mismatch");
      end
      $finish;
   end

   // Check each response beat against the oldest expectation
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("response %0d arrived with nothing expected: %h",
                        beats_checked, rsp_payload);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.read_data       !== want.read_data       ||
                rsp_payload.index_now       !== want.index_now       ||
                rsp_payload.target_now      !== want.target_now      ||
                rsp_payload.auto_inc_off    !== want.auto_inc_off    ||
                rsp_payload.ula_alt_bank    !== want.ula_alt_bank    ||
                rsp_payload.layer2_alt_bank !== want.layer2_alt_bank ||
                rsp_payload.sprite_alt_bank !== want.sprite_alt_bank ||
                rsp_payload.extended_mode   !== want.extended_mode   ||
                rsp_payload.latch_pending   !== want.latch_pending) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"response %0d: expected rd=%h idx=%h tgt=%0d flags=%b latch=%b,",
                            " got rd=%h idx=%h tgt=%0d flags=%b latch=%b"},
                           beats_checked, want.read_data, want.index_now, want.target_now,
                           {want.auto_inc_off, want.sprite_alt_bank, want.layer2_alt_bank,
                            want.ula_alt_bank, want.extended_mode}, want.latch_pending,
                           rsp_payload.read_data, rsp_payload.index_now,
                           rsp_payload.target_now,
                           {rsp_payload.auto_inc_off, rsp_payload.sprite_alt_bank,
                            rsp_payload.layer2_alt_bank, rsp_payload.ula_alt_bank,
                            rsp_payload.extended_mode}, rsp_payload.latch_pending);
            end
         end
         beats_checked++;
      end
   end

endmodule

### files.f
rtl/palreg_pkg.sv
rtl/palreg_ram.sv
rtl/palette_register_port.sv
test/palette_register_port_tb.sv
